[rtl/assert_macros.svh]
// assertion helpers, clocked on i_clk and disabled during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every rising clock edge
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

[rtl/asps_pkg.sv]
package asps_pkg;

    localparam int IN_FRAC_BITS  = 16;
    localparam int OUT_FRAC_BITS = 16;

    localparam int WORK_BITS    = 30;
    localparam int X_W          = 18;
    localparam int A_W          = WORK_BITS + 1;
    localparam int P_W          = 32;
    localparam int PROD_W       = 64;
    localparam int R_W          = 34;
    localparam int RAD_W        = 2 * WORK_BITS + 1;
    localparam int SQ_W         = RAD_W + 1;
    localparam int ROOT_W       = WORK_BITS + 1;
    localparam int SQRT_STEPS   = WORK_BITS + 1;
    localparam int HORNER_STEPS = 3;
    localparam int SIDE_W_DEF   = 1 + P_W;

    localparam logic [A_W-1:0] ONE_IN = A_W'(1) << IN_FRAC_BITS;
    localparam logic [A_W-1:0] ONE_W  = A_W'(1) << WORK_BITS;

    // cubic coefficients in q30, constant term first
    localparam logic signed [P_W-1:0] COEF [HORNER_STEPS+1] = '{
        32'sd1686557207,
        -32'sd227756103,
        32'sd79737142,
        -32'sd20110433
    };
    localparam logic signed [P_W-1:0] HALF_PI = 32'sd1686629713;

    localparam logic signed [PROD_W-1:0] ANGLE_MAX = PROD_W'(2 ** (X_W - 1) - 1);
    localparam logic signed [PROD_W-1:0] ANGLE_MIN = -ANGLE_MAX - PROD_W'(1);

    // arithmetic shift right, rounding to nearest with ties away from zero
    function automatic logic signed [PROD_W-1:0] shr_round(
        input logic signed [PROD_W-1:0] v,
        input int unsigned              sh
    );
        logic signed [PROD_W-1:0] bias;
        if (sh == 0) begin
            return v;
        end
        bias = (PROD_W'(1) << (sh - 1)) - PROD_W'(v[PROD_W-1]);
        return (v + bias) >>> sh;
    endfunction

endpackage

[rtl/asps_if.sv]
interface asps_in_if import asps_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic signed [X_W-1:0] x_value;

    modport source (output valid, output x_value, input ready);
    modport sink (input valid, input x_value, output ready);
endinterface

interface asps_out_if import asps_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic signed [X_W-1:0] angle;

    modport source (output valid, output angle, input ready);
    modport sink (input valid, input angle, output ready);
endinterface

[rtl/asps_sqrt.sv]
module asps_sqrt import asps_pkg::*; #(
    parameter int SIDE_W = SIDE_W_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [RAD_W-1:0]  i_rad,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [ROOT_W-1:0] o_root,
    output logic [SIDE_W-1:0] o_side
);

    typedef struct packed {
        logic              valid;
        logic [SQ_W-1:0]   rem;
        logic [SQ_W-1:0]   res;
        logic [SIDE_W-1:0] side;
    } t_step;

    typedef struct packed {
        logic              valid;
        logic [ROOT_W-1:0] root;
        logic [SIDE_W-1:0] side;
    } t_fin;

    t_step           w_src [SQRT_STEPS];
    t_step           n_st  [SQRT_STEPS];
    t_step           r_st  [SQRT_STEPS];
    logic [SQ_W-1:0] w_bit   [SQRT_STEPS];
    logic [SQ_W-1:0] w_trial [SQRT_STEPS];
    t_fin            n_fin;
    t_fin            r_fin;

    // one result bit per stage
    always_comb begin
        w_src[0] = '{valid: i_valid, rem: SQ_W'(i_rad), res: '0, side: i_side};
        for (int k = 1; k < SQRT_STEPS; k++) begin
            w_src[k] = r_st[k-1];
        end
        for (int k = 0; k < SQRT_STEPS; k++) begin
            w_bit[k]   = SQ_W'(1) << (2 * (SQRT_STEPS - 1 - k));
            w_trial[k] = w_src[k].res + w_bit[k];
            n_st[k]    = w_src[k];
            if (w_src[k].rem >= w_trial[k]) begin
                n_st[k].rem = w_src[k].rem - w_trial[k];
                n_st[k].res = (w_src[k].res >> 1) + w_bit[k];
            end else begin
                n_st[k].res = w_src[k].res >> 1;
            end
        end
    end

    // round to nearest
    always_comb begin
        n_fin.valid = r_st[SQRT_STEPS-1].valid;
        n_fin.side  = r_st[SQRT_STEPS-1].side;
        n_fin.root  = ROOT_W'(r_st[SQRT_STEPS-1].res
                      + SQ_W'(r_st[SQRT_STEPS-1].rem > r_st[SQRT_STEPS-1].res));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < SQRT_STEPS; k++) begin
                r_st[k].valid <= 1'b0;
            end
            r_fin.valid <= 1'b0;
        end else if (i_en) begin
            r_st  <= n_st;
            r_fin <= n_fin;
        end
    end

    assign o_valid = r_fin.valid;
    assign o_root  = r_fin.root;
    assign o_side  = r_fin.side;

endmodule

[rtl/arcsine_poly_sqrt_approx_top.sv]
// Arcsine of a signed 18-bit fixed-point argument (16 fraction bits, clamped to magnitude
// one), returned as an 18-bit signed angle in radians with 16 fraction bits, formed as
// pi/2 - sqrt(1-|x|) * cubic(|x|) in q30 with the sign of x restored. The datapath is a
// 43-stage pipeline that accepts one transaction every cycle while the output side takes
// them; the 31-stage square root (one root bit per stage) follows the 6-stage Horner
// evaluation. A two-entry output buffer lets the pipeline keep its data while the
// output is stalled; input ready drops only once both entries are full.
`include "assert_macros.svh"

module arcsine_poly_sqrt_approx_top import asps_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    asps_in_if.sink    i_in,
    asps_out_if.source o_out
);

    typedef struct packed {
        logic                  neg;
        logic signed [P_W-1:0] p;
    } t_side;

    localparam int SIDE_W = $bits(t_side);

    typedef struct packed {
        logic                  valid;
        logic                  neg;
        logic [A_W-1:0]        a;
        logic signed [P_W-1:0] p;
    } t_hacc;

    typedef struct packed {
        logic                     valid;
        logic                     neg;
        logic [A_W-1:0]           a;
        logic signed [PROD_W-1:0] prod;
    } t_hmul;

    typedef struct packed {
        logic           valid;
        logic           neg;
        logic [A_W-1:0] a;
    } t_dec;

    typedef struct packed {
        logic                     valid;
        logic                     neg;
        logic signed [PROD_W-1:0] prod;
    } t_fmul;

    typedef struct packed {
        logic                  valid;
        logic                  neg;
        logic signed [R_W-1:0] r;
    } t_fsub;

    typedef struct packed {
        logic                  valid;
        logic signed [X_W-1:0] angle;
    } t_fout;

    logic                     w_adv;
    logic [X_W:0]             w_mag;
    logic [A_W-1:0]           w_mag_w;
    t_dec                     n_dec, r_dec;
    t_hacc                    w_hsrc [HORNER_STEPS];
    t_hmul                    n_hmul [HORNER_STEPS];
    t_hmul                    r_hmul [HORNER_STEPS];
    t_hacc                    n_hacc [HORNER_STEPS];
    t_hacc                    r_hacc [HORNER_STEPS];
    logic [RAD_W-1:0]         w_rad;
    logic [SIDE_W-1:0]        w_side_in;
    logic                     w_sq_valid;
    logic [ROOT_W-1:0]        w_sq_root;
    logic [SIDE_W-1:0]        w_sq_side;
    t_side                    w_side_out;
    t_fmul                    n_fmul, r_fmul;
    t_fsub                    n_fsub, r_fsub;
    logic signed [PROD_W-1:0] w_rr;
    t_fout                    n_fout, r_fout;
    logic                     w_take;
    logic                     r_out_v;
    logic signed [X_W-1:0]    r_out_angle;
    logic                     r_skid_v;
    logic signed [X_W-1:0]    r_skid_angle;

    assign w_adv      = !r_skid_v;
    assign i_in.ready = w_adv;

    // magnitude, clamp and scale to q30
    always_comb begin
        w_mag = i_in.x_value[X_W-1] ? (X_W+1)'(-{i_in.x_value[X_W-1], i_in.x_value})
                                    : {1'b0, i_in.x_value};
        w_mag_w = A_W'(w_mag);
        if (w_mag_w > ONE_IN) begin
            w_mag_w = ONE_IN;
        end
        n_dec.valid = i_in.valid;
        n_dec.neg   = i_in.x_value[X_W-1];
        n_dec.a     = w_mag_w << (WORK_BITS - IN_FRAC_BITS);
    end

    // horner steps: multiply stage, then round and add stage
    always_comb begin
        w_hsrc[0] = '{valid: r_dec.valid, neg: r_dec.neg, a: r_dec.a, p: COEF[HORNER_STEPS]};
        for (int j = 1; j < HORNER_STEPS; j++) begin
            w_hsrc[j] = r_hacc[j-1];
        end
        for (int j = 0; j < HORNER_STEPS; j++) begin
            n_hmul[j].valid = w_hsrc[j].valid;
            n_hmul[j].neg   = w_hsrc[j].neg;
            n_hmul[j].a     = w_hsrc[j].a;
            n_hmul[j].prod  = w_hsrc[j].p * $signed({1'b0, w_hsrc[j].a});
            n_hacc[j].valid = r_hmul[j].valid;
            n_hacc[j].neg   = r_hmul[j].neg;
            n_hacc[j].a     = r_hmul[j].a;
            n_hacc[j].p     = P_W'(shr_round(r_hmul[j].prod, WORK_BITS))
                              + COEF[HORNER_STEPS-1-j];
        end
    end

    assign w_rad     = {ONE_W - r_hacc[HORNER_STEPS-1].a, WORK_BITS'(0)};
    assign w_side_in = {r_hacc[HORNER_STEPS-1].neg, r_hacc[HORNER_STEPS-1].p};

    asps_sqrt #(
        .SIDE_W (SIDE_W)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (r_hacc[HORNER_STEPS-1].valid),
        .i_rad   (w_rad),
        .i_side  (w_side_in),
        .o_valid (w_sq_valid),
        .o_root  (w_sq_root),
        .o_side  (w_sq_side)
    );

    assign w_side_out = t_side'(w_sq_side);

    always_comb begin
        n_fmul.valid = w_sq_valid;
        n_fmul.neg   = w_side_out.neg;
        n_fmul.prod  = $signed({1'b0, w_sq_root}) * w_side_out.p;

        n_fsub.valid = r_fmul.valid;
        n_fsub.neg   = r_fmul.neg;
        n_fsub.r     = R_W'(PROD_W'(HALF_PI) - shr_round(r_fmul.prod, WORK_BITS));

        // output rounding, sign and saturation
        w_rr = shr_round(PROD_W'(r_fsub.r), WORK_BITS - OUT_FRAC_BITS);
        if (r_fsub.neg) begin
            w_rr = -w_rr;
        end
        if (w_rr > ANGLE_MAX) begin
            w_rr = ANGLE_MAX;
        end else if (w_rr < ANGLE_MIN) begin
            w_rr = ANGLE_MIN;
        end
        n_fout.valid = r_fsub.valid;
        n_fout.angle = X_W'(w_rr);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dec.valid <= 1'b0;
            for (int j = 0; j < HORNER_STEPS; j++) begin
                r_hmul[j].valid <= 1'b0;
                r_hacc[j].valid <= 1'b0;
            end
            r_fmul.valid <= 1'b0;
            r_fsub.valid <= 1'b0;
            r_fout.valid <= 1'b0;
        end else if (w_adv) begin
            r_dec  <= n_dec;
            r_hmul <= n_hmul;
            r_hacc <= n_hacc;
            r_fmul <= n_fmul;
            r_fsub <= n_fsub;
            r_fout <= n_fout;
        end
    end

    // output register with skid entry
    assign w_take = r_out_v && o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_out_v || w_take) begin
            if (r_skid_v) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_out_v <= w_adv && r_fout.valid;
            end
        end else if (w_adv && r_fout.valid) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_v || w_take) begin
            if (r_skid_v) begin
                r_out_angle <= r_skid_angle;
            end else begin
                r_out_angle <= r_fout.angle;
            end
        end else if (w_adv && r_fout.valid) begin
            r_skid_angle <= r_fout.angle;
        end
    end

    assign o_out.valid = r_out_v;
    assign o_out.angle = r_out_angle;

    `ASSERT_IMPLIES(a_skid_behind_out, r_skid_v, r_out_v, "skid entry full with empty output")
    `ASSERT_IMPLIES(a_skid_fill, $rose(r_skid_v), $past(o_out.valid && !o_out.ready), "skid filled without stall")
    `ASSERT_IMPLIES(a_root_range, w_sq_valid, w_sq_root <= ONE_W, "square root above one")

endmodule

[sim/tb_arcsine_poly_sqrt_approx_top.sv]
module tb_arcsine_poly_sqrt_approx_top;
    timeunit 1ns;
    timeprecision 1ps;

    import asps_pkg::*;

    localparam int     Q_BITS      = 30;
    localparam longint ONE_ARG     = longint'(1) << IN_FRAC_BITS;
    localparam longint ONE_Q       = longint'(1) << Q_BITS;
    localparam longint CUBIC_C0    = 1686557207;
    localparam longint CUBIC_C1    = -227756103;
    localparam longint CUBIC_C2    = 79737142;
    localparam longint CUBIC_C3    = -20110433;
    localparam longint HALF_PI_Q   = 1686629713;
    localparam longint ANGLE_TOP   = 131071;
    localparam longint ANGLE_FLOOR = -131072;
    localparam int     CYCLE_LIMIT = 200000;
    localparam int     DRAIN_WAIT  = 60;
    localparam int     HOLD_CYCLES = 400;
    localparam int     PHASE_ITEMS = 600;
    localparam int     PRESS_ITEMS = 150;
    localparam int     DIRECTED_N  = 20;

    logic i_clk;
    logic i_rst_n;

    asps_in_if  in_bus ();
    asps_out_if out_bus ();

    arcsine_poly_sqrt_approx_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    logic signed [X_W-1:0] pending_x [$];
    logic signed [X_W-1:0] angle_expected [$];
    logic signed [X_W-1:0] want_angle;
    logic                  in_taken = 1'b0;
    logic                  rx_hold_go;
    int                    rx_hold_left = 0;
    int                    src_idle_pct;
    int                    rx_idle_pct;
    int                    mismatch_count = 0;
    int                    cycle_count = 0;

    int directed_args [DIRECTED_N] = '{
        0, 1, -1, 2, -2, 32768, -32768, 46341, -46341, 65535,
        -65535, 65536, -65536, 65537, -65537, 100000, -100000, 131071, -131072, 21845
    };

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // shift right, round to nearest, ties away from zero
    function automatic longint round_shift(longint v, int sh);
        longint unsigned m;
        m = (v < 0) ? unsigned'(-v) : unsigned'(v);
        if (sh > 0) begin
            m = (m + (64'd1 << (sh - 1))) >> sh;
        end
        return (v < 0) ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint unsigned sqrt_nearest(longint unsigned v);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 60;
        while (bitv != 0) begin
            if (v >= root + bitv) begin
                v    = v - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        if (v > root) begin
            root = root + 1;
        end
        return root;
    endfunction

    function automatic logic signed [X_W-1:0] arcsin_of(logic signed [X_W-1:0] x);
        longint mag;
        longint a;
        longint p;
        longint s;
        longint r;
        mag = (x < 0) ? -longint'(x) : longint'(x);
        if (mag > ONE_ARG) begin
            mag = ONE_ARG;
        end
        a = mag <<< (Q_BITS - IN_FRAC_BITS);
        p = CUBIC_C3;
        p = round_shift(p * a, Q_BITS) + CUBIC_C2;
        p = round_shift(p * a, Q_BITS) + CUBIC_C1;
        p = round_shift(p * a, Q_BITS) + CUBIC_C0;
        s = longint'(sqrt_nearest(unsigned'((ONE_Q - a) << Q_BITS)));
        r = HALF_PI_Q - round_shift(s * p, Q_BITS);
        r = round_shift(r, Q_BITS - OUT_FRAC_BITS);
        if (x < 0) begin
            r = -r;
        end
        if (r > ANGLE_TOP) begin
            r = ANGLE_TOP;
        end
        if (r < ANGLE_FLOOR) begin
            r = ANGLE_FLOOR;
        end
        return X_W'(r);
    endfunction

    // mostly in-range arguments, some hugging one, some anywhere in the field
    function automatic logic signed [X_W-1:0] random_arg();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
            return X_W'(int'($urandom_range(0, 131072)) - 65536);
        end else if (pick == 7) begin
            return X_W'(($urandom_range(0, 1) ? -1 : 1) * int'($urandom_range(65500, 65600)));
        end
        return X_W'($urandom);
    endfunction

    task automatic report_mismatch(string what, logic signed [X_W-1:0] got,
                                   logic signed [X_W-1:0] want);
        $display("mismatch: %s got %0d want %0d", what, got, want);
        mismatch_count++;
    endtask

    task automatic drain();
        while (pending_x.size() != 0 || angle_expected.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // sender
    always @(negedge i_clk) begin : drive_args
        logic                  offer;
        logic signed [X_W-1:0] next_x;
        offer  = in_bus.valid;
        next_x = in_bus.x_value;
        if (!i_rst_n) begin
            offer = 1'b0;
        end else begin
            if (in_bus.valid && in_taken) begin
                void'(pending_x.pop_front());
                offer = 1'b0;
            end
            if (!offer && pending_x.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
                offer  = 1'b1;
                next_x = pending_x[0];
            end
        end
        in_bus.valid   <= offer;
        in_bus.x_value <= next_x;
    end

    // long receiver hold-off
    always @(negedge i_clk) begin
        if (rx_hold_go) begin
            rx_hold_left <= HOLD_CYCLES;
        end else if (rx_hold_left != 0) begin
            rx_hold_left <= rx_hold_left - 1;
        end
    end

    // receiver
    always @(negedge i_clk) begin
        out_bus.ready <= i_rst_n && rx_hold_left == 0 && $urandom_range(0, 99) >= rx_idle_pct;
    end

    // transaction monitor and angle check
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= in_bus.valid && in_bus.ready;
            if (in_bus.valid && in_bus.ready) begin
                angle_expected.push_back(arcsin_of(in_bus.x_value));
            end
            if (out_bus.valid && out_bus.ready) begin
                if (angle_expected.size() == 0) begin
                    report_mismatch("unexpected angle", out_bus.angle, '0);
                end else begin
                    want_angle = angle_expected.pop_front();
                    if (out_bus.angle !== want_angle) begin
                        report_mismatch("angle", out_bus.angle, want_angle);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        i_rst_n        = 1'b0;
        in_bus.valid   = 1'b0;
        in_bus.x_value = '0;
        out_bus.ready  = 1'b0;
        rx_hold_go     = 1'b0;
        src_idle_pct   = 16;
        rx_idle_pct    = 85;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_args[i]) begin
            pending_x.push_back(X_W'(directed_args[i]));
        end
        drain();

        repeat (PHASE_ITEMS) pending_x.push_back(random_arg());
        drain();

        src_idle_pct = 85;
        rx_idle_pct  = 16;
        repeat (PHASE_ITEMS) pending_x.push_back(random_arg());
        drain();

        src_idle_pct = 0;
        rx_idle_pct  = 0;
        repeat (PHASE_ITEMS) pending_x.push_back(random_arg());
        drain();

        // output blocked while arguments keep coming, so the pipeline backs up
        rx_hold_go <= 1'b1;
        repeat (PRESS_ITEMS) pending_x.push_back(random_arg());
        @(posedge i_clk);
        rx_hold_go <= 1'b0;
        drain();

        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
